>>> design/lld_pkg.sv
package lld_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int PTR_W    = IDX_W + 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TOT_W    = 7;
    localparam int Q_DEPTH  = 2;

    typedef enum logic [2:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_DEL_HEAD = 3'd2,
        OP_DEL_TAIL = 3'd3,
        OP_DEL_VAL  = 3'd4
    } op_code_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Work kinds that the front end sorts each operation into.
    typedef enum logic [2:0] {
        K_NOP,
        K_INS_HEAD,
        K_INS_TAIL,
        K_DEL_HEAD,
        K_DEL_TAIL,
        K_DEL_VAL
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_READ,
        S_WAIT,
        S_CHECK,
        S_UNLINK,
        S_FREE,
        S_RESULT
    } eng_state_t;

endpackage

>>> design/linked_list_deque_engine_top.sv
// Linked list deque engine: bounded list of signed 32-bit values in a 64-node pool.
// Full, empty or ignored operations return a result without touching the list; an insert
// at the tail also patches the old tail's link, and a delete walks the list from the head,
// one node read at a time, then refreshes the head and tail values unless the list empties.
// The engine takes one operation at a time; the front end queues up to two more.
// Reset (rst_n, asynchronous, active low) empties the list and frees every node.
module linked_list_deque_engine_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         operation,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [6:0]         entry_total,
    output logic signed [31:0] head_value,
    output logic signed [31:0] tail_value
);
    import lld_pkg::*;

    // Commands pass from the front end to the engine through a short queue.
    logic q_valid;
    logic q_stall;
    cmd_t q_cmd;

    // The front end classifies each transfer and queues it.
    lld_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (in_valid),
        .stall     (in_stall),
        .operation (operation),
        .value     (value),
        .q_valid   (q_valid),
        .q_stall   (q_stall),
        .q_cmd     (q_cmd)
    );

    // The back end walks and edits the list and holds the result register.
    lld_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_stall     (q_stall),
        .q_cmd       (q_cmd),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .entry_total (entry_total),
        .head_value  (head_value),
        .tail_value  (tail_value)
    );

endmodule

>>> design/lld_front.sv
module lld_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               stall,
    input  logic [2:0]         operation,
    input  logic signed [31:0] value,
    output logic               q_valid,
    input  logic               q_stall,
    output lld_pkg::cmd_t      q_cmd
);
    import lld_pkg::*;

    // Small FIFO that decouples classification from the list engine.
    cmd_t                    q_mem [Q_DEPTH];
    logic [$clog2(Q_DEPTH)-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [$clog2(Q_DEPTH):0]   fill_reg;
    cmd_t                    cmd_in;
    logic                    push, pop;

    always_comb
    begin
        case (operation)
            OP_INS_HEAD: cmd_in.kind = K_INS_HEAD;
            OP_INS_TAIL: cmd_in.kind = K_INS_TAIL;
            OP_DEL_HEAD: cmd_in.kind = K_DEL_HEAD;
            OP_DEL_TAIL: cmd_in.kind = K_DEL_TAIL;
            OP_DEL_VAL:  cmd_in.kind = K_DEL_VAL;
            default:     cmd_in.kind = K_NOP;
        endcase
        cmd_in.value = value;
    end

    assign stall   = (fill_reg == ($clog2(Q_DEPTH)+1)'(Q_DEPTH));
    assign push    = valid && !stall;
    assign q_valid = (fill_reg != '0);
    assign pop     = q_valid && !q_stall;
    assign q_cmd   = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= ($clog2(Q_DEPTH)+1)'(Q_DEPTH))
        else $error("queue overfilled");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("fill count lost a push");
    a_empty_novalid: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> !q_valid)
        else $error("valid from empty queue");

endmodule

>>> design/lld_back.sv
module lld_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    output logic                       q_stall,
    input  lld_pkg::cmd_t              q_cmd,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 status,
    output logic [6:0]                 entry_total,
    output logic signed [31:0]         head_value,
    output logic signed [31:0]         tail_value
);
    import lld_pkg::*;

    // Node and link memories: one write and one registered read each cycle.
    logic [31:0]      node_mem [CAPACITY];
    logic [PTR_W-1:0] link_mem [CAPACITY];
    // Free stack: valid bits stand in for the reset image (entry i holds i).
    logic [IDX_W-1:0] free_mem [CAPACITY];
    logic [CAPACITY-1:0] free_wr_reg, free_wr_next;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

    eng_state_t state_reg, state_next;
    cmd_t       cmd_reg, cmd_next;
    logic [PTR_W-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [PTR_W-1:0] prev_reg, prev_next, cur_reg, cur_next;
    logic [CNT_W-1:0] count_reg, count_next, free_top_reg, free_top_next;
    logic [CNT_W-1:0] steps_reg, steps_next;
    logic [31:0] hval_reg, hval_next, tval_reg, tval_next;
    logic [1:0]  st_reg, st_next;
    logic        out_valid_reg, out_valid_next;
    // Result register, so that a waiting result is kept apart from the working state.
    logic [1:0]       out_status_reg, out_status_next;
    logic [TOT_W-1:0] out_total_reg, out_total_next;
    logic [31:0]      out_head_reg, out_head_next, out_tail_reg, out_tail_next;

    // Memory ports
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      rd_node;
    logic [PTR_W-1:0] rd_link;
    logic             nw_en, lw_en, fw_en;
    logic [IDX_W-1:0] nw_addr, lw_addr, fw_addr;
    logic [31:0]      nw_data;
    logic [PTR_W-1:0] lw_data;
    logic [IDX_W-1:0] fw_data;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] free_sel;
    logic [IDX_W-1:0] free_rd_reg;

    assign free_sel = IDX_W'(free_top_reg - 1'b1);
    assign free_idx = free_wr_reg[free_sel] ? free_rd_reg : free_sel;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_node <= node_mem[rd_addr];
            rd_link <= link_mem[rd_addr];
        end
        if (nw_en)
        begin
            node_mem[nw_addr] <= nw_data;
        end
        if (lw_en)
        begin
            link_mem[lw_addr] <= lw_data;
        end
        if (fw_en)
        begin
            free_mem[fw_addr] <= fw_data;
        end
        free_rd_reg <= free_mem[free_sel];
    end

    assign q_stall     = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign entry_total = out_total_reg;
    assign head_value  = out_head_reg;
    assign tail_value  = out_tail_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        prev_next = prev_reg;
        cur_next = cur_reg;
        count_next = count_reg;
        free_top_next = free_top_reg;
        steps_next = steps_reg;
        hval_next = hval_reg;
        tval_next = tval_reg;
        st_next = st_reg;
        out_valid_next = out_valid_reg;
        out_status_next = out_status_reg;
        out_total_next = out_total_reg;
        out_head_next = out_head_reg;
        out_tail_next = out_tail_reg;
        free_wr_next = free_wr_reg;
        rd_en = 1'b0;
        rd_addr = '0;
        nw_en = 1'b0; nw_addr = '0; nw_data = '0;
        lw_en = 1'b0; lw_addr = '0; lw_data = '0;
        fw_en = 1'b0; fw_addr = '0; fw_data = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next = q_cmd;
                    st_next = ST_DONE;
                    prev_next = NIL;
                    cur_next = head_reg;
                    steps_next = '0;
                    state_next = S_RESULT;
                    case (q_cmd.kind)
                        K_INS_HEAD, K_INS_TAIL:
                        begin
                            if (free_top_reg == '0)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                // the free stack entry is read this cycle
                                state_next = S_ALLOC;
                            end
                        end
                        K_DEL_HEAD, K_DEL_TAIL:
                        begin
                            if (head_reg == NIL)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        K_DEL_VAL:
                        begin
                            if (head_reg == NIL)
                            begin
                                st_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ALLOC:
            begin
                state_next = S_RESULT;
                nw_en = 1'b1; nw_addr = free_idx; nw_data = cmd_reg.value;
                lw_en = 1'b1; lw_addr = free_idx;
                free_top_next = free_top_reg - 1'b1;
                count_next = count_reg + 1'b1;
                if (head_reg == NIL)
                begin
                    lw_data = NIL;
                    head_next = {1'b0, free_idx};
                    tail_next = {1'b0, free_idx};
                    hval_next = cmd_reg.value;
                    tval_next = cmd_reg.value;
                end
                else if (cmd_reg.kind == K_INS_TAIL)
                begin
                    lw_data = NIL;
                    tail_next = {1'b0, free_idx};
                    tval_next = cmd_reg.value;
                    // old tail link is patched next cycle
                    cur_next = tail_reg;
                    state_next = S_UNLINK;
                end
                else
                begin
                    lw_data = head_reg;
                    head_next = {1'b0, free_idx};
                    hval_next = cmd_reg.value;
                end
            end
            S_READ:
            begin
                rd_en = 1'b1;
                rd_addr = cur_reg[IDX_W-1:0];
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // rd_node / rd_link hold the node at cur_reg (the head node on the first refresh read)
                if (cmd_reg.kind == K_NOP)
                begin
                    // Value refresh after an unlink: two reads, head then tail.
                    if (steps_reg == '0)
                    begin
                        hval_next = rd_node;
                        rd_en = 1'b1;
                        rd_addr = cur_reg[IDX_W-1:0];
                        steps_next = CNT_W'(1);
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        tval_next = rd_node;
                        state_next = S_RESULT;
                    end
                end
                else if ((cmd_reg.kind == K_DEL_HEAD)
                    || (cmd_reg.kind == K_DEL_TAIL && cur_reg == tail_reg)
                    || (cmd_reg.kind == K_DEL_VAL && rd_node == cmd_reg.value))
                begin
                    state_next = S_UNLINK;
                end
                else if (rd_link == NIL || steps_reg == CNT_W'(CAPACITY - 1))
                begin
                    st_next = (cmd_reg.kind == K_DEL_VAL) ? ST_NOTFOUND : ST_EMPTY;
                    state_next = S_RESULT;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next = rd_link;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_UNLINK:
            begin
                if (cmd_reg.kind == K_INS_TAIL)
                begin
                    lw_en = 1'b1;
                    lw_addr = cur_reg[IDX_W-1:0];
                    lw_data = tail_reg;
                    state_next = S_RESULT;
                end
                else
                begin
                    if (prev_reg != NIL)
                    begin
                        lw_en = 1'b1;
                        lw_addr = prev_reg[IDX_W-1:0];
                        lw_data = rd_link;
                    end
                    else
                    begin
                        head_next = rd_link;
                    end
                    if (tail_reg == cur_reg)
                    begin
                        tail_next = prev_reg;
                    end
                    if (prev_reg == NIL && rd_link == NIL)
                    begin
                        tail_next = NIL;
                    end
                    if (free_top_reg < CNT_W'(CAPACITY))
                    begin
                        fw_en = 1'b1;
                        fw_addr = IDX_W'(free_top_reg);
                        fw_data = cur_reg[IDX_W-1:0];
                        free_wr_next[IDX_W'(free_top_reg)] = 1'b1;
                        free_top_next = free_top_reg + 1'b1;
                    end
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    state_next = S_FREE;
                end
            end
            S_FREE:
            begin
                // refresh the head and tail values from the new pointers
                if (head_reg == NIL)
                begin
                    hval_next = '0;
                    tval_next = '0;
                    state_next = S_RESULT;
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = head_reg[IDX_W-1:0];
                    cur_next = tail_reg;
                    steps_next = '0;
                    state_next = S_WAIT;
                    cmd_next.kind = K_NOP;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_status_next = st_reg;
                    out_total_next = TOT_W'(count_reg);
                    out_head_next = hval_reg;
                    out_tail_next = tval_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg <= NIL;
            tail_reg <= NIL;
            count_reg <= '0;
            free_top_reg <= CNT_W'(CAPACITY);
            free_wr_reg <= '0;
            out_valid_reg <= 1'b0;
            hval_reg <= '0;
            tval_reg <= '0;
            out_status_reg <= '0;
            out_total_reg <= '0;
            out_head_reg <= '0;
            out_tail_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            count_reg <= count_next;
            free_top_reg <= free_top_next;
            free_wr_reg <= free_wr_next;
            out_valid_reg <= out_valid_next;
            hval_reg <= hval_next;
            tval_reg <= tval_next;
            out_status_reg <= out_status_next;
            out_total_reg <= out_total_next;
            out_head_reg <= out_head_next;
            out_tail_reg <= out_tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        prev_reg <= prev_next;
        cur_reg <= cur_next;
        steps_reg <= steps_next;
        st_reg <= st_next;
    end

    a_pool_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg + free_top_reg) == CNT_W'(CAPACITY))
        else $error("pool accounting broken");
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == NIL && tail_reg == NIL))
        else $error("empty list with live pointers");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(out_status_reg)
            && $stable(out_total_reg) && $stable(out_head_reg) && $stable(out_tail_reg))
        else $error("stalled result changed");

endmodule
